@@ rtl/pse_pkg.sv @@
// Shared types, constants and helper functions of the Playfair stream encryptor.
package pse_pkg;

   // Letter codes, A is zero.
   localparam logic [4:0] CODE_X = 5'd23;
   localparam logic [4:0] CODE_I = 5'd8;
   localparam logic [4:0] CODE_J = 5'd9;

   // ASCII bounds of the letters.
   localparam logic [7:0] ASCII_UPPER_A = 8'd65;
   localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
   localparam logic [7:0] ASCII_LOWER_A = 8'd97;
   localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
   localparam logic [6:0] ASCII_OUT_A   = 7'd65;
   localparam logic [6:0] ASCII_OUT_Z   = 7'd90;
   localparam logic [4:0] CODE_MAX      = 5'd25;

   // Key square geometry.
   localparam int SQUARE_DIM = 5;
   localparam logic [2:0] LAST_INDEX = 3'd4;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_ROWS_0_1 = 2'd0;
   localparam logic [1:0] CSR_ROWS_2_3 = 2'd1;
   localparam logic [1:0] CSR_ROW_4    = 2'd2;

   // Job queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   // Square entry [row][col] sits at bits 5*(5*row+col) of the flattened registers.
   typedef logic [SQUARE_DIM-1:0][SQUARE_DIM-1:0][4:0] square_type;

   // One unit of work for the back part: a letter pair, or an empty end marker.
   typedef struct packed {
      logic       is_pair;
      logic       last;
      logic [4:0] first;
      logic [4:0] second;
   } job_type;

   // Row and column of a letter in the square.
   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
   } pos_type;

   // Locate a letter; the first match in row-major order wins, no match gives (0,0).
   function automatic pos_type find_pos(square_type sq, logic [4:0] code);
      pos_type p;
      p = '0;
      for (int r = SQUARE_DIM - 1; r >= 0; r--) begin
         for (int c = SQUARE_DIM - 1; c >= 0; c--) begin
            if (sq[r][c] == code) begin
               p.row = 3'(r);
               p.col = 3'(c);
            end
         end
      end
      return p;
   endfunction

   // Step a row or column index forward with wraparound.
   function automatic logic [2:0] inc_wrap(logic [2:0] v);
      return (v == LAST_INDEX) ? 3'd0 : v + 3'd1;
   endfunction

   // Letter code to upper-case ASCII; codes past Z saturate to Z.
   function automatic logic [6:0] to_ascii(logic [4:0] code);
      return (code > CODE_MAX) ? ASCII_OUT_Z : ASCII_OUT_A + {2'b00, code};
   endfunction

endpackage

@@ rtl/pse_ifs.sv @@
// Channel interfaces of the Playfair stream encryptor: plaintext, ciphertext and registers.
interface pse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       message_end;
   modport source (output valid, char_code, message_end, input ready);
   modport sink   (input valid, char_code, message_end, output ready);
endinterface

interface pse_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] cipher_char;
   logic       has_char;
   logic       last_of_run;
   modport source (output valid, cipher_char, has_char, last_of_run, input ready);
   modport sink   (input valid, cipher_char, has_char, last_of_run, output ready);
endinterface

interface pse_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_index;
   logic [49:0] write_data;
   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

@@ rtl/pse_front.sv @@
// Front part: filters and folds plaintext bytes, forms letter pairs and queues jobs.
module pse_front (
   input  logic              clock,
   input  logic              reset,
   pse_req_if.sink           req_bus,
   input  logic              q_full,
   output logic              q_push,
   output pse_pkg::job_type  q_job
);

   logic             held_valid_ff, held_valid_in;
   logic [4:0]       held_letter_ff, held_letter_in;
   logic             pend_valid_ff, pend_valid_in;
   pse_pkg::job_type pend_job_ff, pend_job_in;

   logic             accept;
   logic             is_letter;
   logic [4:0]       code;
   logic             job0_valid, job1_valid;
   pse_pkg::job_type job0, job1;
   logic             hold_valid_next;
   logic [4:0]       hold_letter_next;

   // A second job of the same beat blocks the input until it is written to the queue.
   assign req_bus.ready = !pend_valid_ff && !q_full;
   assign accept        = req_bus.valid && req_bus.ready;

   // Classify the byte and derive the jobs it causes.
   always_comb begin
      is_letter        = 1'b0;
      code             = '0;
      job0_valid       = 1'b0;
      job1_valid       = 1'b0;
      job0             = '0;
      job1             = '0;
      hold_valid_next  = held_valid_ff;
      hold_letter_next = held_letter_ff;

      if (req_bus.char_code >= pse_pkg::ASCII_UPPER_A &&
          req_bus.char_code <= pse_pkg::ASCII_UPPER_Z) begin
         is_letter = 1'b1;
         code      = 5'(req_bus.char_code - pse_pkg::ASCII_UPPER_A);
      end else if (req_bus.char_code >= pse_pkg::ASCII_LOWER_A &&
                   req_bus.char_code <= pse_pkg::ASCII_LOWER_Z) begin
         is_letter = 1'b1;
         code      = 5'(req_bus.char_code - pse_pkg::ASCII_LOWER_A);
      end
      if (is_letter && code == pse_pkg::CODE_J) begin
         code = pse_pkg::CODE_I;
      end

      if (is_letter) begin
         if (!held_valid_ff) begin
            // Open a pair; a message end pads it at once.
            if (req_bus.message_end) begin
               job0_valid = 1'b1;
               job0       = '{is_pair: 1'b1, last: 1'b1, first: code, second: pse_pkg::CODE_X};
               hold_valid_next  = 1'b0;
               hold_letter_next = '0;
            end else begin
               hold_valid_next  = 1'b1;
               hold_letter_next = code;
            end
         end else if (held_letter_ff == code) begin
            // Repeated letter: split with X, the repeat opens the next pair.
            job0_valid = 1'b1;
            job0 = '{is_pair: 1'b1, last: 1'b0, first: held_letter_ff,
                     second: pse_pkg::CODE_X};
            if (req_bus.message_end) begin
               job1_valid = 1'b1;
               job1 = '{is_pair: 1'b1, last: 1'b1, first: code, second: pse_pkg::CODE_X};
               hold_valid_next  = 1'b0;
               hold_letter_next = '0;
            end else begin
               hold_valid_next  = 1'b1;
               hold_letter_next = code;
            end
         end else begin
            // Ordinary pair closes.
            job0_valid = 1'b1;
            job0 = '{is_pair: 1'b1, last: req_bus.message_end, first: held_letter_ff,
                     second: code};
            hold_valid_next  = 1'b0;
            hold_letter_next = '0;
         end
      end else if (req_bus.message_end) begin
         job0_valid = 1'b1;
         if (held_valid_ff) begin
            job0 = '{is_pair: 1'b1, last: 1'b1, first: held_letter_ff,
                     second: pse_pkg::CODE_X};
         end else begin
            job0 = '{is_pair: 1'b0, last: 1'b1, first: 5'd0, second: 5'd0};
         end
         hold_valid_next  = 1'b0;
         hold_letter_next = '0;
      end
   end

   // Queue write: a pending second job goes first, else the first job of this beat.
   always_comb begin
      q_push = 1'b0;
      q_job  = job0;
      if (pend_valid_ff) begin
         q_push = !q_full;
         q_job  = pend_job_ff;
      end else if (accept && job0_valid) begin
         q_push = 1'b1;
      end
   end

   // Next values of the pair state and the pending job.
   always_comb begin
      held_valid_in  = accept ? hold_valid_next : held_valid_ff;
      held_letter_in = accept ? hold_letter_next : held_letter_ff;
      pend_job_in    = pend_job_ff;
      pend_valid_in  = pend_valid_ff;
      if (pend_valid_ff && !q_full) begin
         pend_valid_in = 1'b0;
      end else if (accept && job1_valid) begin
         pend_valid_in = 1'b1;
         pend_job_in   = job1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff  <= 1'b0;
         held_letter_ff <= '0;
         pend_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff  <= held_valid_in;
         held_letter_ff <= held_letter_in;
         pend_valid_ff  <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_job_ff <= pend_job_in;
   end

endmodule

@@ rtl/pse_queue.sv @@
// Short job queue that decouples the front and back parts.
module pse_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pse_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output pse_pkg::job_type  head_job
);

   pse_pkg::job_type                   slots_ff [pse_pkg::QUEUE_DEPTH];
   logic [pse_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [pse_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [pse_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;

   assign full      = count_ff == pse_pkg::QUEUE_CNT_W'(pse_pkg::QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head_job  = slots_ff[rd_ptr_ff];

   // Pointer and fill count updates; the depth is a power of two so pointers wrap freely.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTH
   // The fill count never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pse_pkg::QUEUE_CNT_W'(pse_pkg::QUEUE_DEPTH))
      else $error("job queue count exceeds depth");

   // The front never writes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("job queue written while full");

   // The back never reads an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("job queue read while empty");
`endif

endmodule

@@ rtl/pse_back.sv @@
// Back part: looks up pair letters in the key square, encrypts them and drives result beats.
module pse_back (
   input  logic                 clock,
   input  logic                 reset,
   input  pse_pkg::square_type  square,
   input  logic                 q_not_empty,
   input  pse_pkg::job_type     q_job,
   output logic                 q_pop,
   pse_rsp_if.source            rsp_bus
);

   // Lookup stage.
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_is_pair_ff, s1_last_ff;
   pse_pkg::pos_type s1_pa_ff, s1_pb_ff;

   // Output stage.
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_is_pair_ff, s2_last_ff;
   logic [6:0]       s2_ch0_ff, s2_ch1_ff;
   logic             s2_beat_ff, s2_beat_in;

   logic             s2_final_beat, s2_done, s2_free, s1_adv;
   pse_pkg::pos_type e1, e2;
   logic [6:0]       ch0, ch1;

   // Stage handshakes.
   assign s2_final_beat = !s2_is_pair_ff || s2_beat_ff;
   assign s2_done       = s2_valid_ff && rsp_bus.ready && s2_final_beat;
   assign s2_free       = !s2_valid_ff || s2_done;
   assign s1_adv        = s1_valid_ff && s2_free;
   assign q_pop         = q_not_empty && (!s1_valid_ff || s1_adv);

   // Playfair rules: same row shifts right, same column shifts down, else swap corners.
   always_comb begin
      if (s1_pa_ff.row == s1_pb_ff.row) begin
         e1 = '{row: s1_pa_ff.row, col: pse_pkg::inc_wrap(s1_pa_ff.col)};
         e2 = '{row: s1_pb_ff.row, col: pse_pkg::inc_wrap(s1_pb_ff.col)};
      end else if (s1_pa_ff.col == s1_pb_ff.col) begin
         e1 = '{row: pse_pkg::inc_wrap(s1_pa_ff.row), col: s1_pa_ff.col};
         e2 = '{row: pse_pkg::inc_wrap(s1_pb_ff.row), col: s1_pb_ff.col};
      end else begin
         e1 = '{row: s1_pa_ff.row, col: s1_pb_ff.col};
         e2 = '{row: s1_pb_ff.row, col: s1_pa_ff.col};
      end
      ch0 = pse_pkg::to_ascii(square[e1.row][e1.col]);
      ch1 = pse_pkg::to_ascii(square[e2.row][e2.col]);
   end

   // Stage occupancy and beat counter.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (q_pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      s2_beat_in  = s2_beat_ff;
      if (s1_adv) begin
         s2_valid_in = 1'b1;
         s2_beat_in  = 1'b0;
      end else if (s2_done) begin
         s2_valid_in = 1'b0;
         s2_beat_in  = 1'b0;
      end else if (s2_valid_ff && rsp_bus.ready) begin
         s2_beat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s2_beat_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s2_beat_ff  <= s2_beat_in;
      end
   end

   // Payload registers of both stages.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_is_pair_ff <= q_job.is_pair;
         s1_last_ff    <= q_job.last;
         s1_pa_ff      <= pse_pkg::find_pos(square, q_job.first);
         s1_pb_ff      <= pse_pkg::find_pos(square, q_job.second);
      end
      if (s1_adv) begin
         s2_is_pair_ff <= s1_is_pair_ff;
         s2_last_ff    <= s1_last_ff;
         s2_ch0_ff     <= ch0;
         s2_ch1_ff     <= ch1;
      end
   end

   // Result beat: two letters for a pair, one empty beat for an end marker.
   assign rsp_bus.valid       = s2_valid_ff;
   assign rsp_bus.has_char    = s2_is_pair_ff;
   assign rsp_bus.cipher_char = !s2_is_pair_ff ? 7'd0 : (s2_beat_ff ? s2_ch1_ff : s2_ch0_ff);
   assign rsp_bus.last_of_run = s2_last_ff && s2_final_beat;

endmodule

@@ rtl/playfair_stream_encryptor.sv @@
// Top level of the Playfair stream encryptor: key square registers, front, queue and back.
//
//   Channel   Direction  Beat contents
//   req_bus   in         char_code, message_end: one plaintext byte
//   rsp_bus   out        cipher_char, has_char, last_of_run: one ciphertext letter
//   csr_bus   in         reg_index, write_data: one key square register write
//
// The back part sends one result beat per cycle while rsp_bus is ready, so a byte that closes
// a pair yields two beats, and a repeated letter at message end, which yields two pairs, four.
// Bytes that yield no result are taken every cycle while the job queue has room and no
// second job is pending. A result passes the queue, the lookup stage and the output stage.
// Reset is synchronous, clears the square to all A and drops any held letter.
// A stalled result holds the output stage; the queue keeps taking bytes until it fills.
module playfair_stream_encryptor (
   input  logic      clock,
   input  logic      reset,
   pse_req_if.sink   req_bus,
   pse_rsp_if.source rsp_bus,
   pse_csr_if.sink   csr_bus
);

   logic [49:0]         rows_0_1_ff, rows_2_3_ff;
   logic [24:0]         row_4_ff;
   pse_pkg::square_type square;

   logic                q_push, q_full, q_pop, q_not_empty;
   pse_pkg::job_type    push_job, head_job;

   // Register writes are always taken.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_0_1_ff <= '0;
         rows_2_3_ff <= '0;
         row_4_ff    <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.reg_index)
            pse_pkg::CSR_ROWS_0_1: rows_0_1_ff <= csr_bus.write_data;
            pse_pkg::CSR_ROWS_2_3: rows_2_3_ff <= csr_bus.write_data;
            pse_pkg::CSR_ROW_4:    row_4_ff    <= csr_bus.write_data[24:0];
            default: ;
         endcase
      end
   end

   // Entry 5*row+col lies at bits 5*(5*row+col) of the concatenated rows.
   assign square = {row_4_ff, rows_2_3_ff, rows_0_1_ff};

   pse_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_job   (push_job)
   );

   pse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   pse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .square      (square),
      .q_not_empty (q_not_empty),
      .q_job       (head_job),
      .q_pop       (q_pop),
      .rsp_bus     (rsp_bus)
   );

endmodule
